>>> sv/pts_pkg.sv
package pts_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_RUN  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // Status codes on the result channel
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] period;
      logic [31:0] start_due;
      logic [31:0] now;
      logic [2:0]  task_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic        fired;
      logic        late;
      logic [31:0] run_total;
      logic [31:0] overrun_total;
      logic [31:0] slot_period;
      logic [31:0] slot_next_due;
      logic [3:0]  fired_count;
      logic [31:0] all_overruns;
      logic        last;
   } rsp_type;

   // One row of the task table
   typedef struct packed {
      logic [31:0] period;
      logic [31:0] due;
      logic [31:0] runs;
      logic [31:0] overruns;
   } task_row_type;

   // Which result the datapath builds into the output register
   typedef enum logic [2:0] {
      RSP_ADD_OK,
      RSP_FULL,
      RSP_READ_MISS,
      RSP_READ_HIT,
      RSP_FIRED,
      RSP_SUMMARY
   } rsp_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        req_load;
      logic        add_write;
      logic        run_init;
      logic        idx_clr;
      logic        idx_inc;
      logic        rd_walk;
      logic        rd_req;
      logic        capture;
      logic        update;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       table_full;
      logic       read_hit;
      logic       walk_end;
      logic       cur_fired;
   } dp_stat_type;

endpackage

>>> sv/periodic_task_scheduler.sv
// Periodic task scheduler with a table of MAX_TASKS tasks.
// Request channel (req_valid/req_ready/req_data): one beat per command:
// add a task, run at time now, or read one slot's statistics.
// Result channel (rsp_valid/rsp_ready/rsp_data): add and read give one beat;
// a run gives one beat per fired task in slot order, then a summary beat.
// The final beat of each command has last set; command code 3 gives none.
// Steps: an add or a read of a free slot goes from decode straight to its
// result beat; a read of a slot in use first waits on the table read.
// A run's update pass visits each slot in use through WALK_RD (table read),
// WALK_DIFF (subtract) and WALK_UPD (compare and write back through the
// registered-read task table); the report pass then reads each fired slot
// and loads its beat, skipping slots that did not fire, and ends with the
// summary beat.
// One command is in flight at a time: req_ready is high only while idle,
// which starts the cycle after the final beat of the previous command is taken.
// When the receiver stalls, the current result beat holds in the output
// register and the block waits; nothing is dropped.
// Reset (synchronous) empties the table and clears the overrun sum;
// table rows are written by add and need no clearing.
module periodic_task_scheduler
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pts_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> sv/pts_ram.sv
module pts_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/pts_dp.sv
module pts_dp
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   req_type              req_ff, req_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [MAX_TASKS-1:0] fired_mask_ff, fired_mask_in;
   logic [MAX_TASKS-1:0] late_mask_ff, late_mask_in;
   logic [3:0]           ran_ff, ran_in;
   logic [31:0]          all_ovr_ff, all_ovr_in;
   task_row_type         row_ff, row_in;
   logic [31:0]          diff_ff, diff_in;
   rsp_type              rsp_ff, rsp_in;

   logic [ADDR_W-1:0]    cur_addr;
   logic [ADDR_W-1:0]    req_addr;
   logic [ADDR_W-1:0]    add_addr;
   logic                 due_now;
   logic                 late_now;
   task_row_type         upd_row;
   task_row_type         add_row;
   task_row_type         ram_rdata;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   task_row_type         ram_wdata;
   logic                 ram_re;
   logic [ADDR_W-1:0]    ram_raddr;

   assign cur_addr = idx_ff[ADDR_W-1:0];
   assign add_addr = count_ff[ADDR_W-1:0];
   assign req_addr = ADDR_W'(req_ff.task_index);

   // Status toward the controller
   assign stat.command    = req_ff.command;
   assign stat.table_full = (count_ff == CNT_W'(MAX_TASKS));
   assign stat.read_hit   = (32'(req_ff.task_index) < 32'(count_ff));
   assign stat.walk_end   = (idx_ff == count_ff);
   assign stat.cur_fired  = fired_mask_ff[cur_addr];

   // Firing step: wrap-safe due test, late test and re-arm
   assign due_now  = ~diff_ff[31];
   assign late_now = (row_ff.period != 32'd0) && (diff_ff >= row_ff.period);

   always_comb begin
      upd_row          = row_ff;
      upd_row.runs     = row_ff.runs + 32'd1;
      upd_row.overruns = row_ff.overruns + 32'(late_now);
      if (row_ff.period == 32'd0) begin
         upd_row.due = req_ff.now;
      end else begin
         upd_row.due = req_ff.now + row_ff.period;
      end
   end

   assign add_row = '{period: req_ff.period, due: req_ff.start_due,
                      runs: 32'd0, overruns: 32'd0};

   // Table port selection
   assign ram_we    = cmd.add_write | (cmd.update & due_now);
   assign ram_waddr = cmd.add_write ? add_addr : cur_addr;
   assign ram_wdata = cmd.add_write ? add_row : upd_row;
   assign ram_re    = cmd.rd_walk | cmd.rd_req;
   assign ram_raddr = cmd.rd_req ? req_addr : cur_addr;

   pts_ram #(
      .WIDTH ($bits(task_row_type)),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Next values of datapath registers
   always_comb begin
      req_in        = req_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      fired_mask_in = fired_mask_ff;
      late_mask_in  = late_mask_ff;
      ran_in        = ran_ff;
      all_ovr_in    = all_ovr_ff;
      row_in        = row_ff;
      diff_in       = diff_ff;
      rsp_in        = rsp_ff;

      if (cmd.req_load) begin
         req_in = req_data;
      end
      if (cmd.add_write) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.run_init) begin
         fired_mask_in = '0;
         late_mask_in  = '0;
         ran_in        = 4'd0;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.capture) begin
         row_in  = ram_rdata;
         diff_in = req_ff.now - ram_rdata.due;
      end
      if (cmd.update && due_now) begin
         fired_mask_in[cur_addr] = 1'b1;
         late_mask_in[cur_addr]  = late_now;
         ran_in                  = ran_ff + 4'd1;
         all_ovr_in              = all_ovr_ff + 32'(late_now);
      end

      // Result builder
      if (cmd.rsp_load) begin
         rsp_in              = '0;
         rsp_in.all_overruns = all_ovr_ff;
         rsp_in.last         = 1'b1;
         unique case (cmd.rsp_sel)
            RSP_ADD_OK: begin
               rsp_in.slot          = 3'(add_addr);
               rsp_in.slot_period   = req_ff.period;
               rsp_in.slot_next_due = req_ff.start_due;
            end
            RSP_FULL: begin
               rsp_in.status = ST_FULL;
            end
            RSP_READ_MISS: begin
               rsp_in.status = ST_MISS;
            end
            RSP_READ_HIT: begin
               rsp_in.slot          = req_ff.task_index;
               rsp_in.run_total     = ram_rdata.runs;
               rsp_in.overrun_total = ram_rdata.overruns;
               rsp_in.slot_period   = ram_rdata.period;
               rsp_in.slot_next_due = ram_rdata.due;
            end
            RSP_FIRED: begin
               rsp_in.slot          = 3'(cur_addr);
               rsp_in.fired         = 1'b1;
               rsp_in.late          = late_mask_ff[cur_addr];
               rsp_in.run_total     = ram_rdata.runs;
               rsp_in.overrun_total = ram_rdata.overruns;
               rsp_in.slot_period   = ram_rdata.period;
               rsp_in.slot_next_due = ram_rdata.due;
               rsp_in.last          = 1'b0;
            end
            RSP_SUMMARY: begin
               rsp_in.fired_count = ran_ff;
            end
            default: begin
               rsp_in = rsp_ff;
            end
         endcase
      end
   end

   // The task count and overrun sum reset; the other registers do not
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         all_ovr_ff <= 32'd0;
      end else begin
         count_ff   <= count_in;
         all_ovr_ff <= all_ovr_in;
      end
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      fired_mask_ff <= fired_mask_in;
      late_mask_ff  <= late_mask_in;
      ran_ff        <= ran_in;
      row_ff        <= row_in;
      diff_ff       <= diff_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/pts_ctrl.sv
module pts_ctrl
   import pts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      IDLE,
      DECODE,
      READ_WAIT,
      WALK_RD,
      WALK_DIFF,
      WALK_UPD,
      EMIT_RD,
      EMIT_LOAD,
      RESP_MID,
      RESP_LAST
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == RESP_MID) || (state_ff == RESP_LAST);

   // Commands and next state
   always_comb begin
      cmd         = '0;
      cmd.rsp_sel = RSP_SUMMARY;
      state_in    = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = DECODE;
            end
         end
         DECODE: begin
            unique case (stat.command)
               CMD_ADD: begin
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_sel   = stat.table_full ? RSP_FULL : RSP_ADD_OK;
                  cmd.add_write = ~stat.table_full;
                  state_in      = RESP_LAST;
               end
               CMD_READ: begin
                  if (stat.read_hit) begin
                     cmd.rd_req = 1'b1;
                     state_in   = READ_WAIT;
                  end else begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = RSP_READ_MISS;
                     state_in     = RESP_LAST;
                  end
               end
               CMD_RUN: begin
                  cmd.run_init = 1'b1;
                  cmd.idx_clr  = 1'b1;
                  state_in     = WALK_RD;
               end
               default: begin
                  state_in = IDLE;
               end
            endcase
         end
         READ_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = RSP_READ_HIT;
            state_in     = RESP_LAST;
         end
         // Update pass: read and compare each slot in use, write back those that are due
         WALK_RD: begin
            if (stat.walk_end) begin
               cmd.idx_clr = 1'b1;
               state_in    = EMIT_RD;
            end else begin
               cmd.rd_walk = 1'b1;
               state_in    = WALK_DIFF;
            end
         end
         WALK_DIFF: begin
            cmd.capture = 1'b1;
            state_in    = WALK_UPD;
         end
         WALK_UPD: begin
            cmd.update  = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = WALK_RD;
         end
         // Report pass: one beat per fired slot, then the summary
         EMIT_RD: begin
            if (stat.walk_end) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_SUMMARY;
               state_in     = RESP_LAST;
            end else if (stat.cur_fired) begin
               cmd.rd_walk = 1'b1;
               state_in    = EMIT_LOAD;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         EMIT_LOAD: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = RSP_FIRED;
            cmd.idx_inc  = 1'b1;
            state_in     = RESP_MID;
         end
         RESP_MID: begin
            if (rsp_ready) begin
               state_in = EMIT_RD;
            end
         end
         RESP_LAST: begin
            if (rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
